@@ rtl/core/rqsr_pkg.sv @@
`default_nettype none

package rqsr_pkg;

    // Operation codes carried on i_op
    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SEEK = 2'd2
    } t_op;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEEK = 2'b10
    } t_state;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic push;    // first free cell takes the pushed word
        logic shift;   // every cell takes its upper neighbor (drop head)
        logic rotate;  // like shift, but the last full cell takes the head word
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ rtl/core/rqsr_cell.sv @@
`default_nettype none

module rqsr_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rqsr_pkg::t_cell_cmd    i_cmd,
    input  wire logic [DATA_WIDTH-1:0]  i_push_word,
    input  wire logic [DATA_WIDTH-1:0]  i_head_word,
    input  wire logic                   i_prev_valid,
    input  wire logic                   i_next_valid,
    input  wire logic [DATA_WIDTH-1:0]  i_next_word,
    output logic                        o_valid,
    output logic [DATA_WIDTH-1:0]       o_word
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_word;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] n_word;
    logic                  first_free;
    logic                  last_full;

    // Locate this cell within the run of occupied cells
    assign first_free = !r_valid && i_prev_valid;
    assign last_full  = r_valid && !i_next_valid;

    // Pick the next word and occupancy for this cell
    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (i_cmd.push) begin
            if (first_free) begin
                n_valid = 1'b1;
                n_word  = i_push_word;
            end
        end else if (i_cmd.shift) begin
            n_valid = i_next_valid;
            n_word  = i_next_word;
        end else if (i_cmd.rotate) begin
            n_word = last_full ? i_head_word : i_next_word;
        end
    end

    // Hold occupancy under reset; words need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ rtl/core/ring_queue_with_seek_remove_top.sv @@
`default_nettype none

// Bounded queue of signed words with enqueue, dequeue and seek-remove.
// Command channel: drive i_op and i_value with start high; the word is taken
// at a rising edge where start is high and busy is low.
// Result channel: o_valid is high for exactly one cycle with o_data_out,
// o_ok, o_passed and o_occupancy; the receiver cannot stall it, so it must
// take the word in that cycle.
// Enqueue and dequeue results show in the cycle after acceptance and busy
// stays low, so a new word may follow every cycle.
// Seek-remove raises busy while the chain rotates entries past the head,
// until it finds the key or sees every entry passed; its result shows in
// the cycle in which busy falls. The cell chain moves every entry by one
// cell per cycle while the head is compared.
// Entries sit in a chain of cells with the head in cell zero; dequeue and a
// found key shift the chain down, a rotation also moves the head word to
// the last occupied cell.
// Reset (synchronous, active low) empties the queue and returns to idle.
module ring_queue_with_seek_remove_top #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_op,
    input  wire logic signed [DATA_WIDTH-1:0]   i_value,
    output logic                                o_valid,
    output logic signed [DATA_WIDTH-1:0]        o_data_out,
    output logic                                o_ok,
    output logic [$clog2(DEPTH+1)-1:0]          o_passed,
    output logic [$clog2(DEPTH+1)-1:0]          o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [DATA_WIDTH-1:0] INT_MIN = ~({DATA_WIDTH{1'b1}} >> 1);

    rqsr_pkg::t_state      r_state, n_state;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]         r_total, n_total;
    logic [CW-1:0]         r_moved, n_moved;
    logic [CW-1:0]         r_fill, n_fill;

    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_ok, n_ok;
    logic [CW-1:0]         r_passed, n_passed;
    logic [CW-1:0]         r_occ, n_occ;

    rqsr_pkg::t_cell_cmd   cmd;
    logic                  accept;
    logic                  w_valid [DEPTH];
    logic [DATA_WIDTH-1:0] w_word  [DEPTH];
    logic [DATA_WIDTH-1:0] head_word;

    assign busy      = (r_state == rqsr_pkg::ST_SEEK);
    assign accept    = start && !busy;
    assign head_word = w_word[0];

    // Build the chain of cells, head at cell zero
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                  prev_valid;
        logic                  next_valid;
        logic [DATA_WIDTH-1:0] next_word;

        if (gi == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_inner_prev
            assign prev_valid = w_valid[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign next_valid = 1'b0;
            assign next_word  = '0;
        end else begin : g_inner_next
            assign next_valid = w_valid[gi+1];
            assign next_word  = w_word[gi+1];
        end

        rqsr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_push_word  (i_value),
            .i_head_word  (head_word),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_next_word  (next_word),
            .o_valid      (w_valid[gi]),
            .o_word       (w_word[gi])
        );
    end

    // Decode commands and step the seek sequence
    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_key       = r_key;
        n_total     = r_total;
        n_moved     = r_moved;
        n_fill      = r_fill;
        n_out_valid = 1'b0;
        n_data      = r_data;
        n_ok        = r_ok;
        n_passed    = r_passed;
        n_occ       = r_occ;

        unique case (r_state)
            rqsr_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        rqsr_pkg::OP_ENQ: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_passed    = '0;
                            if (r_fill != FULL_COUNT) begin
                                cmd.push = 1'b1;
                                n_fill   = r_fill + CW'(1);
                                n_ok     = 1'b1;
                            end else begin
                                n_ok = 1'b0;
                            end
                            n_occ = n_fill;
                        end
                        rqsr_pkg::OP_DEQ: begin
                            n_out_valid = 1'b1;
                            n_passed    = '0;
                            if (r_fill != '0) begin
                                cmd.shift = 1'b1;
                                n_fill    = r_fill - CW'(1);
                                n_data    = head_word;
                                n_ok      = 1'b1;
                            end else begin
                                n_data = INT_MIN;
                                n_ok   = 1'b0;
                            end
                            n_occ = n_fill;
                        end
                        rqsr_pkg::OP_SEEK: begin
                            n_state = rqsr_pkg::ST_SEEK;
                            n_key   = i_value;
                            n_total = r_fill;
                            n_moved = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_ok        = 1'b0;
                            n_passed    = '0;
                            n_occ       = r_fill;
                        end
                    endcase
                end
            end
            rqsr_pkg::ST_SEEK: begin
                if (r_moved == r_total) begin
                    // every entry passed once: order is back as it was
                    n_state     = rqsr_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_ok        = 1'b0;
                    n_passed    = r_moved;
                    n_occ       = r_fill;
                end else if (head_word == r_key) begin
                    cmd.shift   = 1'b1;
                    n_fill      = r_fill - CW'(1);
                    n_state     = rqsr_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_ok        = 1'b1;
                    n_passed    = r_moved;
                    n_occ       = n_fill;
                end else begin
                    cmd.rotate = 1'b1;
                    n_moved    = r_moved + CW'(1);
                end
            end
            default: begin
                n_state = rqsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqsr_pkg::ST_IDLE;
            r_fill      <= '0;
            r_moved     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_moved     <= n_moved;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_data   <= n_data;
        r_ok     <= n_ok;
        r_passed <= n_passed;
        r_occ    <= n_occ;
    end

    assign o_valid     = r_out_valid;
    assign o_data_out  = r_data;
    assign o_ok        = r_ok;
    assign o_passed    = r_passed;
    assign o_occupancy = r_occ;

    // The head cell is occupied exactly when the fill count is nonzero
    a_head_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == (r_fill != '0))
        else $error("head cell occupancy disagrees with fill count");

    // Any command other than a seek yields a result word in the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op != rqsr_pkg::OP_SEEK) |=> o_valid)
        else $error("missing result after enqueue or dequeue");

    // A seek never passes more entries than it started with
    a_seek_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_moved <= r_total && r_total <= FULL_COUNT))
        else $error("seek passed count out of range");

    // Leaving the seek state always posts a result word
    a_seek_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && n_state == rqsr_pkg::ST_IDLE) |=> (o_valid && !busy))
        else $error("seek finished without a result");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int QDEPTH = 128;
    localparam int DWIDTH = 32;
    localparam int CWIDTH = $clog2(QDEPTH + 1);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [DWIDTH-1:0] WORD_MIN = {1'b1, {(DWIDTH-1){1'b0}}};
    localparam logic [DWIDTH-1:0] WORD_MAX = {1'b0, {(DWIDTH-1){1'b1}}};
    localparam int ITEM_TARGET = 1500;

    typedef struct {
        logic [DWIDTH-1:0] data;
        logic              ok;
        logic [CWIDTH-1:0] passed;
        logic [CWIDTH-1:0] occupancy;
    } t_reply;

    // Tracks the queue contents and the replies still owed by the block
    class rq_scoreboard;
        logic [DWIDTH-1:0] slots [QDEPTH];
        bit [6:0]          head_slot;   // 7-bit indexes wrap at the depth
        bit [6:0]          tail_slot;
        int unsigned       fill;
        t_reply            pending_replies [$];
        int unsigned       errors;
        int unsigned       words_seen;
        int unsigned       found;
        int unsigned       missed;
        int unsigned       full_drops;
        int unsigned       empty_pops;
        int unsigned       max_passed;

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function logic [DWIDTH-1:0] held_word(int unsigned k);
            return slots[(head_slot + k) % QDEPTH];
        endfunction

        // Apply one accepted command word and queue the reply it causes
        function void note_word(logic [1:0] op, logic [DWIDTH-1:0] value);
            t_reply            r;
            logic [DWIDTH-1:0] w;
            int unsigned       start_fill;
            int unsigned       moved;
            r.data = '0;
            r.ok = 1'b0;
            r.passed = '0;
            moved = 0;
            words_seen++;
            case (op)
                rqsr_pkg::OP_ENQ: begin
                    if (fill < QDEPTH) begin
                        slots[tail_slot] = value;
                        tail_slot++;
                        fill++;
                        r.ok = 1'b1;
                    end else begin
                        full_drops++;
                    end
                end
                rqsr_pkg::OP_DEQ: begin
                    if (fill > 0) begin
                        r.data = slots[head_slot];
                        head_slot++;
                        fill--;
                        r.ok = 1'b1;
                    end else begin
                        r.data = WORD_MIN;
                        empty_pops++;
                    end
                end
                rqsr_pkg::OP_SEEK: begin
                    // rotate head to tail until the key reaches the head and is dropped, or every entry has passed
                    start_fill = fill;
                    while (moved < start_fill) begin
                        w = slots[head_slot];
                        head_slot++;
                        fill--;
                        if (w == value) begin
                            r.ok = 1'b1;
                            break;
                        end
                        slots[tail_slot] = w;
                        tail_slot++;
                        fill++;
                        moved++;
                    end
                    if (r.ok) found++;
                    else missed++;
                    if (moved > max_passed) max_passed = moved;
                end
                default: ;
            endcase
            r.passed = moved[CWIDTH-1:0];
            r.occupancy = fill[CWIDTH-1:0];
            pending_replies.push_back(r);
        endfunction

        // Compare one result word with the oldest reply owed
        task check_word(t_reply got);
            t_reply want;
            if (pending_replies.size() == 0) begin
                report($sformatf("result with none expected (data %h ok %b passed %0d occ %0d)",
                                 got.data, got.ok, got.passed, got.occupancy));
            end else begin
                want = pending_replies.pop_front();
                if (got.data !== want.data)
                    report($sformatf("data_out %h, expected %h", got.data, want.data));
                if (got.ok !== want.ok)
                    report($sformatf("ok %b, expected %b", got.ok, want.ok));
                if (got.passed !== want.passed)
                    report($sformatf("passed %0d, expected %0d", got.passed, want.passed));
                if (got.occupancy !== want.occupancy)
                    report($sformatf("occupancy %0d, expected %0d",
                                     got.occupancy, want.occupancy));
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_op;
    logic signed [DWIDTH-1:0] i_value;
    logic                     o_valid;
    logic signed [DWIDTH-1:0] o_data_out;
    logic                     o_ok;
    logic [CWIDTH-1:0]        o_passed;
    logic [CWIDTH-1:0]        o_occupancy;

    rq_scoreboard board = new();
    int unsigned  sent;
    bit           steady;   // no idling during the current phase

    ring_queue_with_seek_remove_top #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (DWIDTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_data_out  (o_data_out),
        .o_ok        (o_ok),
        .o_passed    (o_passed),
        .o_occupancy (o_occupancy)
    );

    // Toggle the clock every half period
    always #5 i_clk = ~i_clk;

    // Check results first: they belong to words taken on earlier edges
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n) begin
            if (o_valid) begin
                got.data = o_data_out;
                got.ok = o_ok;
                got.passed = o_passed;
                got.occupancy = o_occupancy;
                board.check_word(got);
            end
            if (start && !busy)
                board.note_word(i_op, i_value);
        end
    end

    // Present one word and hold it until the block takes it
    task send_word(logic [1:0] op, logic [DWIDTH-1:0] value);
        @(negedge i_clk);
        start = 1'b1;
        i_op = op;
        i_value = value;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sent++;
    endtask

    // Idle with start low and noise on the payload; n sets how long
    task idle_for(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
            i_op = 2'($urandom);
            i_value = $urandom;
        end
    endtask

    task random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return;
        if (r < 90) idle_for($urandom_range(1, 3));
        else idle_for($urandom_range(10, 40));
    endtask

    // Hold off until every owed reply has arrived
    task wait_for_replies();
        @(negedge i_clk);
        start = 1'b0;
        while (board.pending_replies.size() > 0)
            @(posedge i_clk);
    endtask

    function logic [DWIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom;
        if (r < 85) return DWIDTH'($signed($urandom_range(0, 7)) - 2);
        case ($urandom_range(0, 3))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Key: mostly a word currently held, otherwise anything
    function logic [DWIDTH-1:0] pick_key();
        if (board.fill > 0 && $urandom_range(0, 99) < 60)
            return board.held_word($urandom_range(0, board.fill - 1));
        return pick_value();
    endfunction

    task send_mixed(int enq_pct, int deq_pct, int seek_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct) send_word(rqsr_pkg::OP_ENQ, pick_value());
        else if (r < enq_pct + deq_pct) send_word(rqsr_pkg::OP_DEQ, pick_value());
        else if (r < enq_pct + deq_pct + seek_pct) send_word(rqsr_pkg::OP_SEEK, pick_key());
        else send_word(OP_UNUSED, pick_value());
        random_gap();
    endtask

    // Fill to capacity, push past it, then seek in the full queue
    task fill_to_brim();
        while (board.fill + board.pending_replies.size() < QDEPTH) begin
            send_word(rqsr_pkg::OP_ENQ, pick_value());
            random_gap();
        end
        repeat ($urandom_range(2, 4)) begin
            send_word(rqsr_pkg::OP_ENQ, pick_value());
            random_gap();
        end
        wait_for_replies();
        send_word(rqsr_pkg::OP_SEEK, $urandom);
        send_word(rqsr_pkg::OP_SEEK, board.held_word(QDEPTH - 1));
        send_word(rqsr_pkg::OP_SEEK, pick_key());
    endtask

    initial begin
        int kind;
        int len;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = rqsr_pkg::OP_ENQ;
        i_value = '0;
        sent = 0;
        steady = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty cases, extreme words, every seek outcome
        send_word(rqsr_pkg::OP_DEQ, '0);
        send_word(rqsr_pkg::OP_SEEK, '0);
        send_word(OP_UNUSED, '1);
        send_word(rqsr_pkg::OP_ENQ, WORD_MIN);
        send_word(rqsr_pkg::OP_ENQ, WORD_MAX);
        idle_for(2);
        send_word(rqsr_pkg::OP_ENQ, '0);
        send_word(rqsr_pkg::OP_ENQ, '1);
        send_word(rqsr_pkg::OP_ENQ, 32'h5555_5555);
        send_word(rqsr_pkg::OP_ENQ, 32'hAAAA_AAAA);
        send_word(OP_UNUSED, 32'h1234_5678);
        send_word(rqsr_pkg::OP_SEEK, WORD_MIN);
        send_word(rqsr_pkg::OP_SEEK, 32'hAAAA_AAAA);
        send_word(rqsr_pkg::OP_SEEK, 32'h0001_2345);
        idle_for(3);
        send_word(rqsr_pkg::OP_SEEK, '1);
        send_word(rqsr_pkg::OP_ENQ, 32'd7);
        send_word(rqsr_pkg::OP_ENQ, 32'd7);
        send_word(rqsr_pkg::OP_SEEK, 32'd7);
        repeat (5) send_word(rqsr_pkg::OP_DEQ, '0);
        send_word(rqsr_pkg::OP_DEQ, '0);
        wait_for_replies();

        fill_to_brim();
        wait_for_replies();

        // Random phases of varied character
        while (sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 8);
            len = $urandom_range(20, 120);
            steady = ($urandom_range(0, 9) < 3);
            if (kind == 8) begin
                fill_to_brim();
            end else begin
                repeat (len) begin
                    case (kind % 4)
                        0: send_mixed(75, 10, 12);
                        1: send_mixed(15, 65, 17);
                        2: send_mixed(30, 15, 52);
                        default: send_mixed(40, 25, 32);
                    endcase
                end
            end
            steady = 1'b0;
            if ($urandom_range(0, 2) == 0) wait_for_replies();
            else random_gap();
        end

        wait_for_replies();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d words: %0d seeks found, %0d not found, longest pass %0d.",
                 board.words_seen, board.found, board.missed, board.max_passed);
        $display("Full-queue drops %0d, empty dequeues %0d, mismatches %0d.",
                 board.full_drops, board.empty_pops, board.errors);
        if (board.errors == 0) begin
            $display("[ring_queue_with_seek_remove_top] OK");
        end else begin
            $display("[ring_queue_with_seek_remove_top] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("Timeout with %0d replies owed.", board.pending_replies.size());
        $display("[ring_queue_with_seek_remove_top] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/rqsr_pkg.sv
rtl/core/rqsr_cell.sv
rtl/core/ring_queue_with_seek_remove_top.sv
bench/testbench.sv
